// File: design/rotp_pkg.sv
// ----------------------------------------------------------------------------
// rotp_pkg: shared types and constants for the pivot rotation pipeline
// Holds the field widths, the request and result layouts, the sideband that
// rides alongside the CORDIC, the quadrant codes and the arctangent table.
// ----------------------------------------------------------------------------
package rotp_pkg;

    // Field widths.
    localparam int COORD_WIDTH   = 32;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;

    // Internal formats. The angle is widened to a 32-bit fraction of a turn.
    localparam int TURN_WIDTH  = 32;
    localparam int TURN_SHIFT  = TURN_WIDTH - ANGLE_WIDTH;
    localparam int FRAC_BITS   = 30;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int XY_WIDTH    = FRAC_BITS + 4;
    localparam int Z_WIDTH     = TURN_WIDTH;
    localparam int TRIG_WIDTH  = FRAC_BITS + 2;
    localparam int PROD_WIDTH  = DIFF_WIDTH + TRIG_WIDTH;
    localparam int ROUND_WIDTH = PROD_WIDTH - FRAC_BITS;
    localparam int SUM_WIDTH   = ROUND_WIDTH + 2;

    // CORDIC start value: the limit gain 0.60725293500888 in Q4.30.
    localparam logic signed [XY_WIDTH-1:0] CORDIC_GAIN = XY_WIDTH'(652032874);

    // Quadrant codes taken from the top two bits of the angle.
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    // One request: vertex, pivot and angle.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] coord_a;
        logic signed [COORD_WIDTH-1:0] coord_b;
        logic signed [COORD_WIDTH-1:0] pivot_a;
        logic signed [COORD_WIDTH-1:0] pivot_b;
        logic        [ANGLE_WIDTH-1:0] turn_angle;
    } rotp_in_t;

    // One result: rotated vertex and clip flag.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rotated_a;
        logic signed [COORD_WIDTH-1:0] rotated_b;
        logic                          saturated;
    } rotp_out_t;

    // Offsets from the pivot and the pivot itself, carried past the CORDIC.
    typedef struct packed {
        logic signed [DIFF_WIDTH-1:0]  diff_a;
        logic signed [DIFF_WIDTH-1:0]  diff_b;
        logic signed [COORD_WIDTH-1:0] pivot_a;
        logic signed [COORD_WIDTH-1:0] pivot_b;
    } rotp_side_t;

    // Arctangent of 2^-idx in units of 2^-32 turn, truncated.
    function automatic logic signed [Z_WIDTH-1:0] atan_turn(input int unsigned idx);
        logic signed [Z_WIDTH-1:0] val;
        case (idx)
            0:       val = Z_WIDTH'(536870912);
            1:       val = Z_WIDTH'(316933406);
            2:       val = Z_WIDTH'(167458907);
            3:       val = Z_WIDTH'(85004756);
            4:       val = Z_WIDTH'(42667331);
            5:       val = Z_WIDTH'(21354465);
            6:       val = Z_WIDTH'(10680862);
            7:       val = Z_WIDTH'(5340245);
            8:       val = Z_WIDTH'(2670163);
            9:       val = Z_WIDTH'(1335087);
            10:      val = Z_WIDTH'(667544);
            11:      val = Z_WIDTH'(333772);
            12:      val = Z_WIDTH'(166886);
            13:      val = Z_WIDTH'(83443);
            14:      val = Z_WIDTH'(41721);
            15:      val = Z_WIDTH'(20860);
            16:      val = Z_WIDTH'(10430);
            17:      val = Z_WIDTH'(5215);
            18:      val = Z_WIDTH'(2607);
            19:      val = Z_WIDTH'(1303);
            20:      val = Z_WIDTH'(651);
            21:      val = Z_WIDTH'(325);
            22:      val = Z_WIDTH'(162);
            23:      val = Z_WIDTH'(81);
            24:      val = Z_WIDTH'(40);
            25:      val = Z_WIDTH'(20);
            26:      val = Z_WIDTH'(10);
            27:      val = Z_WIDTH'(5);
            28:      val = Z_WIDTH'(2);
            29:      val = Z_WIDTH'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: design/rotp_cordic.sv
// ----------------------------------------------------------------------------
// rotp_cordic: unrolled rotation-mode CORDIC for sine and cosine
// One register stage per iteration, then a stage that maps the first-quadrant
// result to the full turn and clamps both values to plus or minus one.
// ----------------------------------------------------------------------------
module rotp_cordic (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  up_valid,
    output logic                                  up_stall,
    input  rotp_pkg::rotp_side_t                  up_side,
    input  logic [1:0]                            up_quadrant,
    input  logic signed [rotp_pkg::Z_WIDTH-1:0]   up_angle,
    output logic                                  dn_valid,
    input  logic                                  dn_stall,
    output rotp_pkg::rotp_side_t                  dn_side,
    output logic signed [rotp_pkg::TRIG_WIDTH-1:0] dn_cos,
    output logic signed [rotp_pkg::TRIG_WIDTH-1:0] dn_sin
);
    import rotp_pkg::*;

    localparam logic signed [XY_WIDTH-1:0] UNIT_POS = XY_WIDTH'(1) << FRAC_BITS;
    localparam logic signed [XY_WIDTH-1:0] UNIT_NEG = -UNIT_POS;

    // Taps: index 0 is the stage input, index i+1 the register of stage i.
    logic                      v_tap    [CORDIC_STAGES+1];
    logic signed [XY_WIDTH-1:0] x_tap   [CORDIC_STAGES+1];
    logic signed [XY_WIDTH-1:0] y_tap   [CORDIC_STAGES+1];
    logic signed [Z_WIDTH-1:0]  z_tap   [CORDIC_STAGES+1];
    logic [1:0]                quad_tap [CORDIC_STAGES+1];
    rotp_side_t                side_tap [CORDIC_STAGES+1];
    logic                      move     [CORDIC_STAGES+1];

    logic                        t_v_reg;
    logic signed [TRIG_WIDTH-1:0] cos_reg, cos_next;
    logic signed [TRIG_WIDTH-1:0] sin_reg, sin_next;
    rotp_side_t                  t_side_reg;

    // Clamp a Q4.30 value to the closed unit interval, returned in Q2.30.
    function automatic logic signed [TRIG_WIDTH-1:0] clamp_unit(
        input logic signed [XY_WIDTH-1:0] v
    );
        logic signed [XY_WIDTH-1:0] c;
        if (v > UNIT_POS) begin
            c = UNIT_POS;
        end
        else if (v < UNIT_NEG) begin
            c = UNIT_NEG;
        end
        else begin
            c = v;
        end
        return c[TRIG_WIDTH-1:0];
    endfunction

    // Start of the iteration chain.
    assign v_tap[0]    = up_valid;
    assign x_tap[0]    = CORDIC_GAIN;
    assign y_tap[0]    = '0;
    assign z_tap[0]    = up_angle;
    assign quad_tap[0] = up_quadrant;
    assign side_tap[0] = up_side;
    assign up_stall    = !move[0];

    // The mapping stage moves when empty or when its result is taken.
    assign move[CORDIC_STAGES] = !t_v_reg || !dn_stall;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic                       v_reg;
        logic signed [XY_WIDTH-1:0] x_reg, x_next;
        logic signed [XY_WIDTH-1:0] y_reg, y_next;
        logic signed [Z_WIDTH-1:0]  z_reg, z_next;
        logic [1:0]                 quad_reg;
        rotp_side_t                 side_reg;
        logic signed [XY_WIDTH-1:0] x_shift;
        logic signed [XY_WIDTH-1:0] y_shift;

        // A stage takes new data when it is empty or its content moves on.
        assign move[i] = !v_reg || move[i+1];

        // One micro-rotation, direction chosen by the sign of the residue.
        always_comb
        begin
            x_shift = x_tap[i] >>> i;
            y_shift = y_tap[i] >>> i;
            if (!z_tap[i][Z_WIDTH-1]) begin
                x_next = x_tap[i] - y_shift;
                y_next = y_tap[i] + x_shift;
                z_next = z_tap[i] - atan_turn(i);
            end
            else begin
                x_next = x_tap[i] + y_shift;
                y_next = y_tap[i] - x_shift;
                z_next = z_tap[i] + atan_turn(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg <= 1'b0;
            end
            else if (move[i]) begin
                v_reg <= v_tap[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (move[i]) begin
                x_reg    <= x_next;
                y_reg    <= y_next;
                z_reg    <= z_next;
                quad_reg <= quad_tap[i];
                side_reg <= side_tap[i];
            end
        end

        assign v_tap[i+1]    = v_reg;
        assign x_tap[i+1]    = x_reg;
        assign y_tap[i+1]    = y_reg;
        assign z_tap[i+1]    = z_reg;
        assign quad_tap[i+1] = quad_reg;
        assign side_tap[i+1] = side_reg;
    end

    // Rotate the first-quadrant pair into the requested quadrant and clamp.
    always_comb
    begin
        case (quad_tap[CORDIC_STAGES])
            QUAD_SECOND: begin
                cos_next = clamp_unit(-y_tap[CORDIC_STAGES]);
                sin_next = clamp_unit(x_tap[CORDIC_STAGES]);
            end
            QUAD_THIRD: begin
                cos_next = clamp_unit(-x_tap[CORDIC_STAGES]);
                sin_next = clamp_unit(-y_tap[CORDIC_STAGES]);
            end
            QUAD_FOURTH: begin
                cos_next = clamp_unit(y_tap[CORDIC_STAGES]);
                sin_next = clamp_unit(-x_tap[CORDIC_STAGES]);
            end
            default: begin
                cos_next = clamp_unit(x_tap[CORDIC_STAGES]);
                sin_next = clamp_unit(y_tap[CORDIC_STAGES]);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            t_v_reg <= 1'b0;
        end
        else if (move[CORDIC_STAGES]) begin
            t_v_reg <= v_tap[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (move[CORDIC_STAGES]) begin
            cos_reg    <= cos_next;
            sin_reg    <= sin_next;
            t_side_reg <= side_tap[CORDIC_STAGES];
        end
    end

    assign dn_valid = t_v_reg;
    assign dn_side  = t_side_reg;
    assign dn_cos   = cos_reg;
    assign dn_sin   = sin_reg;

endmodule

// File: design/rotp_combine.sv
// ----------------------------------------------------------------------------
// rotp_combine: products, rounding and saturating sums
// Three register stages: the four offset-by-trig products, their rounding to
// the coordinate scale, then the sums with the pivot and the clip to range.
// ----------------------------------------------------------------------------
module rotp_combine (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   up_valid,
    output logic                                   up_stall,
    input  rotp_pkg::rotp_side_t                   up_side,
    input  logic signed [rotp_pkg::TRIG_WIDTH-1:0] up_cos,
    input  logic signed [rotp_pkg::TRIG_WIDTH-1:0] up_sin,
    output logic                                   dn_valid,
    input  logic                                   dn_stall,
    output rotp_pkg::rotp_out_t                    dn_result
);
    import rotp_pkg::*;

    localparam logic signed [PROD_WIDTH-1:0] ROUND_BIAS = PROD_WIDTH'(1) << (FRAC_BITS - 1);

    // Stage valid bits and moves.
    logic p_v_reg, r_v_reg, o_v_reg;
    logic p_move, r_move, o_move;

    // Product stage.
    logic signed [PROD_WIDTH-1:0]  ac_reg, bs_reg, as_reg, bc_reg;
    logic signed [PROD_WIDTH-1:0]  ac_next, bs_next, as_next, bc_next;
    logic signed [COORD_WIDTH-1:0] p_pa_reg, p_pb_reg;

    // Rounding stage.
    logic signed [ROUND_WIDTH-1:0] rac_reg, rbs_reg, ras_reg, rbc_reg;
    logic signed [PROD_WIDTH-1:0]  rac_full, rbs_full, ras_full, rbc_full;
    logic signed [COORD_WIDTH-1:0] r_pa_reg, r_pb_reg;

    // Output stage.
    logic signed [SUM_WIDTH-1:0] sum_a, sum_b;
    logic                        ovf_a, ovf_b;
    rotp_out_t                   result_reg, result_next;

    assign o_move   = !o_v_reg || !dn_stall;
    assign r_move   = !r_v_reg || o_move;
    assign p_move   = !p_v_reg || r_move;
    assign up_stall = !p_move;

    // Four signed products of offset and unit-scaled trig value.
    always_comb
    begin
        ac_next = PROD_WIDTH'(up_side.diff_a) * PROD_WIDTH'(up_cos);
        bs_next = PROD_WIDTH'(up_side.diff_b) * PROD_WIDTH'(up_sin);
        as_next = PROD_WIDTH'(up_side.diff_a) * PROD_WIDTH'(up_sin);
        bc_next = PROD_WIDTH'(up_side.diff_b) * PROD_WIDTH'(up_cos);
    end

    // Round half up back to the coordinate scale.
    always_comb
    begin
        rac_full = (ac_reg + ROUND_BIAS) >>> FRAC_BITS;
        rbs_full = (bs_reg + ROUND_BIAS) >>> FRAC_BITS;
        ras_full = (as_reg + ROUND_BIAS) >>> FRAC_BITS;
        rbc_full = (bc_reg + ROUND_BIAS) >>> FRAC_BITS;
    end

    // Exact sums with the pivot, then clip when the top bits disagree.
    always_comb
    begin
        sum_a = SUM_WIDTH'(r_pa_reg) + SUM_WIDTH'(rac_reg) - SUM_WIDTH'(rbs_reg);
        sum_b = SUM_WIDTH'(r_pb_reg) + SUM_WIDTH'(ras_reg) + SUM_WIDTH'(rbc_reg);
        ovf_a = (sum_a[SUM_WIDTH-1:COORD_WIDTH-1] != '0)
             && (sum_a[SUM_WIDTH-1:COORD_WIDTH-1] != '1);
        ovf_b = (sum_b[SUM_WIDTH-1:COORD_WIDTH-1] != '0)
             && (sum_b[SUM_WIDTH-1:COORD_WIDTH-1] != '1);
        if (ovf_a) begin
            result_next.rotated_a = {sum_a[SUM_WIDTH-1], {(COORD_WIDTH-1){!sum_a[SUM_WIDTH-1]}}};
        end
        else begin
            result_next.rotated_a = sum_a[COORD_WIDTH-1:0];
        end
        if (ovf_b) begin
            result_next.rotated_b = {sum_b[SUM_WIDTH-1], {(COORD_WIDTH-1){!sum_b[SUM_WIDTH-1]}}};
        end
        else begin
            result_next.rotated_b = sum_b[COORD_WIDTH-1:0];
        end
        result_next.saturated = ovf_a || ovf_b;
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p_v_reg <= 1'b0;
            r_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else begin
            if (p_move) begin
                p_v_reg <= up_valid;
            end
            if (r_move) begin
                r_v_reg <= p_v_reg;
            end
            if (o_move) begin
                o_v_reg <= r_v_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (p_move) begin
            ac_reg   <= ac_next;
            bs_reg   <= bs_next;
            as_reg   <= as_next;
            bc_reg   <= bc_next;
            p_pa_reg <= up_side.pivot_a;
            p_pb_reg <= up_side.pivot_b;
        end
        if (r_move) begin
            rac_reg  <= rac_full[ROUND_WIDTH-1:0];
            rbs_reg  <= rbs_full[ROUND_WIDTH-1:0];
            ras_reg  <= ras_full[ROUND_WIDTH-1:0];
            rbc_reg  <= rbc_full[ROUND_WIDTH-1:0];
            r_pa_reg <= p_pa_reg;
            r_pb_reg <= p_pb_reg;
        end
        if (o_move) begin
            result_reg <= result_next;
        end
    end

    assign dn_valid  = o_v_reg;
    assign dn_result = result_reg;

endmodule

// File: design/point_rotation_about_pivot.sv
// ----------------------------------------------------------------------------
// point_rotation_about_pivot: rotate a vertex about a pivot in a plane
// Offsets from the pivot are formed, sine and cosine come from an unrolled
// CORDIC, and the rotated vertex is summed back and clipped to range.
//
//   Channel   Valid          Stall          Payload
//   request   vertex_valid   vertex_stall   vertex (rotp_in_t)
//   result    result_valid   result_stall   result (rotp_out_t)
//
// One request enters per cycle while no stall holds the pipeline. The stages,
// in order: one offset stage, one stage per CORDIC iteration, one quadrant
// stage, then product, rounding and output stages.
// Reset clears only the stage valid bits; the pipeline is empty afterwards.
// Each stage holds while it is full and the next one holds; empty stages keep
// filling, so a stalled result does not stop requests until every stage is full.
// ----------------------------------------------------------------------------
module point_rotation_about_pivot (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vertex_valid,
    output logic                vertex_stall,
    input  rotp_pkg::rotp_in_t  vertex,
    output logic                result_valid,
    input  logic                result_stall,
    output rotp_pkg::rotp_out_t result
);
    import rotp_pkg::*;

    // Offset stage.
    logic                      s0_v_reg;
    logic                      s0_move;
    rotp_side_t                s0_side_reg, s0_side_next;
    logic [1:0]                s0_quad_reg, s0_quad_next;
    logic signed [Z_WIDTH-1:0] s0_angle_reg, s0_angle_next;

    // Between the CORDIC and the combiner.
    logic                         cordic_stall;
    logic                         trig_valid;
    logic                         trig_stall;
    rotp_side_t                   trig_side;
    logic signed [TRIG_WIDTH-1:0] trig_cos;
    logic signed [TRIG_WIDTH-1:0] trig_sin;

    assign s0_move      = !s0_v_reg || !cordic_stall;
    assign vertex_stall = !s0_move;

    // Exact offsets and the split of the angle into quadrant and residue.
    always_comb
    begin
        s0_side_next.diff_a  = {vertex.coord_a[COORD_WIDTH-1], vertex.coord_a}
                             - {vertex.pivot_a[COORD_WIDTH-1], vertex.pivot_a};
        s0_side_next.diff_b  = {vertex.coord_b[COORD_WIDTH-1], vertex.coord_b}
                             - {vertex.pivot_b[COORD_WIDTH-1], vertex.pivot_b};
        s0_side_next.pivot_a = vertex.pivot_a;
        s0_side_next.pivot_b = vertex.pivot_b;
        s0_quad_next  = vertex.turn_angle[ANGLE_WIDTH-1 -: 2];
        s0_angle_next = Z_WIDTH'(vertex.turn_angle[ANGLE_WIDTH-3:0]) << TURN_SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s0_v_reg <= 1'b0;
        end
        else if (s0_move) begin
            s0_v_reg <= vertex_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_move) begin
            s0_side_reg  <= s0_side_next;
            s0_quad_reg  <= s0_quad_next;
            s0_angle_reg <= s0_angle_next;
        end
    end

    // Sine and cosine of the request angle.
    rotp_cordic u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (s0_v_reg),
        .up_stall    (cordic_stall),
        .up_side     (s0_side_reg),
        .up_quadrant (s0_quad_reg),
        .up_angle    (s0_angle_reg),
        .dn_valid    (trig_valid),
        .dn_stall    (trig_stall),
        .dn_side     (trig_side),
        .dn_cos      (trig_cos),
        .dn_sin      (trig_sin)
    );

    // Products, rounding and saturating sums.
    rotp_combine u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (trig_valid),
        .up_stall  (trig_stall),
        .up_side   (trig_side),
        .up_cos    (trig_cos),
        .up_sin    (trig_sin),
        .dn_valid  (result_valid),
        .dn_stall  (result_stall),
        .dn_result (result)
    );

    // Back-pressure at the request side only ever comes from a held result.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_stall |-> (result_valid && result_stall))
        else $error("request stalled while the result side is free");

    // A stall at the request side means the offset stage holds a request.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_stall |-> s0_v_reg)
        else $error("request stalled with an empty offset stage");

    // A clipped result has at least one coordinate at a range limit.
    a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.saturated) |->
            ((result.rotated_a[COORD_WIDTH-2:0] == '1 && !result.rotated_a[COORD_WIDTH-1])
          || (result.rotated_a[COORD_WIDTH-2:0] == '0 && result.rotated_a[COORD_WIDTH-1])
          || (result.rotated_b[COORD_WIDTH-2:0] == '1 && !result.rotated_b[COORD_WIDTH-1])
          || (result.rotated_b[COORD_WIDTH-2:0] == '0 && result.rotated_b[COORD_WIDTH-1])))
        else $error("clip flag set without a coordinate at a limit");

endmodule

// File: sim/point_rotation_about_pivot_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_rotation_about_pivot_tb: self-checking bench for the pivot rotation
// Sends directed corner requests and then random requests through four
// handshake phases. Every accepted request is rotated by an independent
// fixed-point model and queued. Each accepted result is compared field by
// field with the oldest queued rotation.
// ----------------------------------------------------------------------------

import rotp_pkg::*;

// Expected rotations, kept in acceptance order, and the checks against them.
class rotation_scoreboard;

    rotp_out_t   expected_q[$];
    longint      atan_step[32];
    int unsigned request_count;
    int unsigned clip_count;
    int unsigned fail_count;

    function new();
        // Arctangent of 2^-i in units of 2^-32 turn, truncated.
        atan_step = '{536870912, 316933406, 167458907, 85004756, 42667331,
                      21354465, 10680862, 5340245, 2670163, 1335087, 667544,
                      333772, 166886, 83443, 41721, 20860, 10430, 5215, 2607,
                      1303, 651, 325, 162, 81, 40, 20, 10, 5, 2, 1, 0, 0};
        request_count = 0;
        clip_count    = 0;
        fail_count    = 0;
    endfunction

    // Offset times a Q2.30 trig value, rounded half up back to Q16.16.
    function longint round_product(longint offset, longint trig);
        return (offset * trig + (longint'(1) <<< 29)) >>> 30;
    endfunction

    // Clip a wide sum to the coordinate range and note whether it was clipped.
    function longint clip_coord(longint sum, inout bit clipped);
        longint top;
        longint bottom;
        top    = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        bottom = -(longint'(1) <<< (COORD_WIDTH - 1));
        if (sum > top) begin
            clipped = 1'b1;
            return top;
        end
        if (sum < bottom) begin
            clipped = 1'b1;
            return bottom;
        end
        return sum;
    endfunction

    // Rotate the vertex of one request about its pivot.
    function rotp_out_t rotate_point(rotp_in_t req);
        rotp_out_t  res;
        longint     da, db, pa, pb;
        longint     x, y, z, xs, ys, cosv, sinv, ra, rb;
        logic [1:0] quad;
        bit         clipped;
        clipped = 1'b0;
        pa = longint'($signed(req.pivot_a));
        pb = longint'($signed(req.pivot_b));
        da = longint'($signed(req.coord_a)) - pa;
        db = longint'($signed(req.coord_b)) - pb;

        // Quadrant from the top two angle bits, the rest drives the CORDIC.
        quad = req.turn_angle[ANGLE_WIDTH-1 -: 2];
        z    = (longint'(req.turn_angle) << TURN_SHIFT) & 64'h3FFF_FFFF;
        x    = 652032874;
        y    = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step[i];
            end
        end

        // Undo the quadrant reduction.
        case (quad)
            QUAD_SECOND:
            begin
                cosv = -y;
                sinv = x;
            end
            QUAD_THIRD:
            begin
                cosv = -x;
                sinv = -y;
            end
            QUAD_FOURTH:
            begin
                cosv = y;
                sinv = -x;
            end
            default:
            begin
                cosv = x;
                sinv = y;
            end
        endcase
        if (cosv > (longint'(1) <<< 30)) cosv = longint'(1) <<< 30;
        if (cosv < -(longint'(1) <<< 30)) cosv = -(longint'(1) <<< 30);
        if (sinv > (longint'(1) <<< 30)) sinv = longint'(1) <<< 30;
        if (sinv < -(longint'(1) <<< 30)) sinv = -(longint'(1) <<< 30);

        // Sum the rounded products onto the pivot, then clip.
        ra = pa + round_product(da, cosv) - round_product(db, sinv);
        rb = pb + round_product(da, sinv) + round_product(db, cosv);
        ra = clip_coord(ra, clipped);
        rb = clip_coord(rb, clipped);
        res.rotated_a = ra[COORD_WIDTH-1:0];
        res.rotated_b = rb[COORD_WIDTH-1:0];
        res.saturated = clipped;
        return res;
    endfunction

    function void note_request(rotp_in_t req);
        rotp_out_t exp_res;
        exp_res = rotate_point(req);
        expected_q.push_back(exp_res);
        request_count++;
        if (exp_res.saturated) clip_count++;
    endfunction

    function void check_result(rotp_out_t got);
        rotp_out_t exp_res;
        if (expected_q.size() == 0)
        begin
            $error("result with no request outstanding: rotated_a %0d rotated_b %0d",
                   got.rotated_a, got.rotated_b);
            fail_count++;
            return;
        end
        exp_res = expected_q.pop_front();
        if (got.rotated_a !== exp_res.rotated_a)
        begin
            $error("rotated_a mismatch: expected %0d, got %0d",
                   exp_res.rotated_a, got.rotated_a);
            fail_count++;
        end
        if (got.rotated_b !== exp_res.rotated_b)
        begin
            $error("rotated_b mismatch: expected %0d, got %0d",
                   exp_res.rotated_b, got.rotated_b);
            fail_count++;
        end
        if (got.saturated !== exp_res.saturated)
        begin
            $error("saturated mismatch: expected %0b, got %0b",
                   exp_res.saturated, got.saturated);
            fail_count++;
        end
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

endclass

module point_rotation_about_pivot_tb;

    localparam int          LATENCY          = CORDIC_STAGES + 5;
    localparam int          DRAIN_CYCLES     = 2 * LATENCY + 10;
    localparam int          RANDOM_PER_PHASE = 200;
    localparam int unsigned CYCLE_LIMIT      = 200000;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] ONE_Q16   = 32'sd65536;

    localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN = 16'd16384;
    localparam logic [ANGLE_WIDTH-1:0] HALF_TURN    = 16'd32768;
    localparam logic [ANGLE_WIDTH-1:0] EIGHTH_TURN  = 16'd8192;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        vertex_valid = 1'b0;
    logic        vertex_stall;
    rotp_in_t    vertex       = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    rotp_out_t   result;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned cycle_count   = 0;

    rotation_scoreboard board = new();

    point_rotation_about_pivot i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Receiver back-pressure for the current phase.
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watch both channels and score every accepted request and result.
    always @(posedge clk)
    begin
        if (rst_n && vertex_valid && !vertex_stall)
            board.note_request(vertex);
        if (rst_n && result_valid && !result_stall)
            board.check_result(result);
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("point_rotation_about_pivot verification failed");
            $finish;
        end
    end

    // Present one request, after a random idle gap, and hold it until taken.
    task automatic send_request(input rotp_in_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            vertex_valid <= 1'b0;
            @(posedge clk);
        end
        vertex_valid <= 1'b1;
        vertex       <= req;
        @(posedge clk);
        while (vertex_stall) @(posedge clk);
    endtask

    function automatic rotp_in_t make_request(
        input logic signed [COORD_WIDTH-1:0] ca,
        input logic signed [COORD_WIDTH-1:0] cb,
        input logic signed [COORD_WIDTH-1:0] pa,
        input logic signed [COORD_WIDTH-1:0] pb,
        input logic        [ANGLE_WIDTH-1:0] ang
    );
        rotp_in_t req;
        req.coord_a    = ca;
        req.coord_b    = cb;
        req.pivot_a    = pa;
        req.pivot_b    = pb;
        req.turn_angle = ang;
        return req;
    endfunction

    // Random request: mostly ordinary geometry, some raw noise, some far corners.
    function automatic rotp_in_t random_request();
        rotp_in_t    req;
        int unsigned shape;
        shape = $urandom_range(9);
        if (shape < 6)
        begin
            // Pivot within +-256.0 and vertex within +-64.0 of it.
            req.pivot_a = int'($urandom_range(33554431)) - 16777216;
            req.pivot_b = int'($urandom_range(33554431)) - 16777216;
            req.coord_a = req.pivot_a + int'($urandom_range(8388607)) - 4194304;
            req.coord_b = req.pivot_b + int'($urandom_range(8388607)) - 4194304;
        end
        else if (shape < 8)
        begin
            req.pivot_a = $urandom;
            req.pivot_b = $urandom;
            req.coord_a = $urandom;
            req.coord_b = $urandom;
        end
        else
        begin
            // Values near the range limits, which clip often.
            req.coord_a = $urandom_range(1) ? COORD_MAX - $urandom_range(65535)
                                            : COORD_MIN + $urandom_range(65535);
            req.coord_b = $urandom_range(1) ? COORD_MAX - $urandom_range(65535)
                                            : COORD_MIN + $urandom_range(65535);
            req.pivot_a = $urandom_range(1) ? COORD_MAX - $urandom_range(65535)
                                            : COORD_MIN + $urandom_range(65535);
            req.pivot_b = $urandom_range(1) ? COORD_MAX - $urandom_range(65535)
                                            : COORD_MIN + $urandom_range(65535);
        end
        // Now and then sit right on a quadrant boundary or one step either side.
        if ($urandom_range(7) == 0)
            req.turn_angle = {2'($urandom_range(3)), 14'd0} + 16'($urandom_range(2)) - 16'd1;
        else
            req.turn_angle = 16'($urandom);
        return req;
    endfunction

    // Corner requests: quadrant boundaries, angle extremes, offsets wider than
    // the coordinate range, clipping in both directions and alternating bits.
    task automatic run_directed();
        send_request(make_request('0, '0, '0, '0, '0));
        send_request(make_request(ONE_Q16, '0, '0, '0, QUARTER_TURN));
        send_request(make_request(ONE_Q16, '0, '0, '0, HALF_TURN));
        send_request(make_request(ONE_Q16, '0, '0, '0, HALF_TURN + QUARTER_TURN));
        send_request(make_request(ONE_Q16, ONE_Q16, '0, '0, 16'hFFFF));
        send_request(make_request(ONE_Q16, ONE_Q16, '0, '0, 16'd1));
        send_request(make_request(ONE_Q16, '0, '0, '0, EIGHTH_TURN));
        send_request(make_request(ONE_Q16, '0, '0, '0, QUARTER_TURN - 16'd1));
        send_request(make_request(ONE_Q16, '0, '0, '0, HALF_TURN - 16'd1));
        send_request(make_request(ONE_Q16, '0, '0, '0, HALF_TURN + 16'd1));
        send_request(make_request(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, '0));
        send_request(make_request(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, HALF_TURN));
        send_request(make_request(COORD_MAX, COORD_MIN, '0, '0, QUARTER_TURN));
        send_request(make_request(COORD_MIN, COORD_MIN, '0, '0, '0));
        send_request(make_request(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'd12345));
        send_request(make_request(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 16'd40000));
        send_request(make_request(COORD_MAX, COORD_MAX, '0, '0, EIGHTH_TURN));
        send_request(make_request(COORD_MIN, COORD_MIN, '0, '0, EIGHTH_TURN));
        send_request(make_request(COORD_MAX, '0, -32'sd1, '0, HALF_TURN));
        send_request(make_request(32'shAAAA_AAAA, 32'sh5555_5555,
                                  32'sh5555_5555, 32'shAAAA_AAAA, 16'hAAAA));
        send_request(make_request(32'sh5555_5555, 32'shAAAA_AAAA,
                                  32'shAAAA_AAAA, 32'sh5555_5555, 16'h5555));
        send_request(make_request(-32'sd1, -32'sd1, '0, '0, 16'hFFFF));
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned hold_pct);
        send_idle_pct = idle_pct;
        stall_pct     <= hold_pct;
        repeat (RANDOM_PER_PHASE) send_request(random_request());
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_phase(0, 0);
        run_phase(85, 0);
        run_phase(0, 85);
        run_phase(21, 21);
        vertex_valid <= 1'b0;

        // Let the pipeline empty, then allow time for any stray result.
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: corner cases, then random vertices under free flow,",
                 board.request_count);
        $display("sender gaps, receiver stalls and both together; %0d results were clipped.",
                 board.clip_count);
        if (board.fail_count == 0)
            $display("point_rotation_about_pivot verification clean");
        else
            $display("point_rotation_about_pivot verification failed");
        $finish;
    end

endmodule
